// ----- rtl/core/lscc_pkg.sv -----
// Shared widths, register codes and handshake structs of the light cull core.
package lscc_pkg;

  // Coordinate width of positions and sphere centers; the radius and distance widths follow it.
  localparam int COORD_BITS = 24;

  localparam int RAD_W    = COORD_BITS - 1;
  localparam int REACH_W  = COORD_BITS;
  localparam int D0_W     = COORD_BITS + 1;
  localparam int SQ0_W    = 2 * D0_W;
  localparam int DSQ0_W   = SQ0_W + 2;

  localparam int DIR_W    = 16;
  localparam int DIR_BITS = 3 * DIR_W;
  localparam int TRIG_W   = 16;
  localparam int TRIG2_W  = 2 * TRIG_W;
  localparam int INVS_W   = 32;

  localparam int OFF_FRAC = 20;
  localparam int OFF_RND  = 1 << (OFF_FRAC - 1);
  localparam int OFFP_W   = RAD_W + INVS_W;
  localparam int OFF_W    = OFFP_W - OFF_FRAC;

  localparam int Q1_FRAC  = 15;
  localparam int Q_RND    = 1 << (Q1_FRAC - 1);
  localparam int P_W      = OFF_W + DIR_W + 1;
  localparam int R_W      = P_W - Q1_FRAC;
  localparam int D1_W     = R_W + 1;
  localparam int D1_H     = D1_W / 2;
  localparam int D1_HI    = D1_W - D1_H;
  localparam int D1SQ_W   = 2 * D1_W;
  localparam int DSQ1_W   = D1SQ_W + 2;

  localparam int EP_W     = D1_W + DIR_W;
  localparam int E_W      = D1_W + DIR_W + 2;
  localparam int E_H      = E_W / 2;
  localparam int E_HI     = E_W - E_H;

  localparam int E2P_W    = D0_W + DIR_W;
  localparam int E2_W     = E2P_W + 3;
  localparam int E2_H     = E2_W / 2;
  localparam int E2_HI    = E2_W - E2_H;

  // Compare widths: squared dot products against scaled squared lengths.
  localparam int CMP0_W   = 2 * E2_W;
  localparam int CMP1_W   = 2 * E_W;

  // Chunking of the long squared lengths for the cosine and sine multiplies.
  localparam int K0       = (DSQ0_W + 1) / 2;
  localparam int K1       = (DSQ1_W + 2) / 3;

  // Latency through the cone stages, and from an accepted item to its result strobe.
  localparam int CONE_LAT = 9;
  localparam int PIPE_LAT = CONE_LAT + 3;

  // Configuration port.
  localparam int CFG_DATA_W  = 64;
  localparam int PADDR_W     = 6;
  localparam int REG_IDX_LSB = 3;

  typedef enum logic [2:0] {
    REG_POS_X = 3'd0,
    REG_POS_Y = 3'd1,
    REG_POS_Z = 3'd2,
    REG_DIR   = 3'd3,
    REG_ATT   = 3'd4,
    REG_CONE  = 3'd5,
    REG_KIND  = 3'd6
  } lscc_reg_e;

  typedef struct packed {
    logic valid;
    logic spot;
  } lscc_ctl_t;

  typedef struct packed {
    logic valid;
    logic affected;
  } lscc_res_t;

endpackage

// ----- rtl/core/lscc_cone.sv -----
// Cone, exclusion and final decision stages of the light cull pipeline.
module lscc_cone (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lscc_pkg::lscc_ctl_t                 ctl_i,
  input  logic signed [lscc_pkg::D0_W-1:0]    d0_i [3],
  input  logic [lscc_pkg::DSQ0_W-1:0]         dsq0_i,
  input  logic [2*lscc_pkg::REACH_W-1:0]      reach2_i,
  input  logic [2*lscc_pkg::RAD_W-1:0]        rad2_i,
  input  logic signed [lscc_pkg::E2_W-1:0]    e2_i,
  input  logic [lscc_pkg::OFF_W-1:0]          off_i,
  input  logic [lscc_pkg::DIR_BITS-1:0]       dir_i,
  input  logic [lscc_pkg::TRIG2_W-1:0]        c2_i,
  input  logic [lscc_pkg::TRIG2_W-1:0]        s2_i,
  output lscc_pkg::lscc_res_t                 res_o
);
  import lscc_pkg::*;

  lscc_ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q, ctl7_q, ctl8_q;
  lscc_res_t res_q;

  logic signed [DIR_W-1:0] dir_s [3];
  logic signed [OFF_W:0]   off_s;
  logic [E2_W-1:0]         e2_u;
  logic [E2_HI-1:0]        e2_hi;
  logic [E2_H-1:0]         e2_lo;

  // Stage 1
  logic signed [P_W-1:0]     p1_q [3];
  logic signed [D0_W-1:0]    d0_1_q [3];
  logic                      reach_ok1_q, rad_ok1_q, e2pos1_q;
  logic [2*E2_HI-1:0]        e2hh1_q;
  logic [E2_W-1:0]           e2hl1_q;
  logic [2*E2_H-1:0]         e2ll1_q;
  logic [K0+TRIG2_W-1:0]     s0lo1_q;
  logic [DSQ0_W-K0+TRIG2_W-1:0] s0hi1_q;

  // Stage 2
  logic signed [P_W-1:0]     prr [3];
  logic signed [R_W-1:0]     r2_q [3];
  logic signed [D0_W-1:0]    d0_2_q [3];
  logic                      reach_ok2_q, rad_ok2_q, e2pos2_q;
  logic [CMP0_W-1:0]         e2sq2_q, rhs0_2_q;

  // Stage 3
  logic signed [D1_W-1:0]    d1_3_q [3];
  logic                      reach_ok3_q, rad_ok3_q, excl3_q;

  // Stage 4
  logic [D1_W-1:0]           d1m [3];
  logic [2*D1_HI-1:0]        hh4_q [3];
  logic [D1_W-1:0]           hl4_q [3];
  logic [2*D1_H-1:0]         ll4_q [3];
  logic signed [EP_W-1:0]    ep4_q [3];
  logic                      reach_ok4_q, rad_ok4_q, excl4_q;

  // Stage 5
  logic [D1SQ_W-1:0]         d1sq5_q [3];
  logic signed [E_W-1:0]     e5_q;
  logic                      reach_ok5_q, rad_ok5_q, excl5_q;

  // Stage 6
  logic [E_W-1:0]            e_u;
  logic [E_HI-1:0]           e_hi;
  logic [E_H-1:0]            e_lo;
  logic [DSQ1_W-1:0]         dsq1_6_q;
  logic [2*E_HI-1:0]         ehh6_q;
  logic [E_W-1:0]            ehl6_q;
  logic [2*E_H-1:0]          ell6_q;
  logic                      reach_ok6_q, rad_ok6_q, excl6_q, epos6_q;

  // Stage 7
  logic [CMP1_W-1:0]         esq7_q;
  logic [K1+TRIG2_W-1:0]     t0_7_q, t1_7_q;
  logic [DSQ1_W-2*K1+TRIG2_W-1:0] t2_7_q;
  logic                      reach_ok7_q, rad_ok7_q, excl7_q, epos7_q;

  // Stage 8
  logic [CMP1_W-1:0]         esq8_q, rhs1_8_q;
  logic                      reach_ok8_q, rad_ok8_q, excl8_q, epos8_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dir_s[k] = dir_i[DIR_W*k +: DIR_W];
      prr[k]   = p1_q[k] + P_W'(Q_RND);
      d1m[k]   = d1_3_q[k][D1_W-1] ? D1_W'(-d1_3_q[k]) : D1_W'(d1_3_q[k]);
    end
  end

  assign off_s = {1'b0, off_i};
  assign e2_u  = e2_i;
  assign e2_hi = e2_u[E2_W-1:E2_H];
  assign e2_lo = e2_u[E2_H-1:0];
  assign e_u   = e5_q;
  assign e_hi  = e_u[E_W-1:E_H];
  assign e_lo  = e_u[E_H-1:0];

  // Control travels with the data; only the valid flags need a reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
      ctl6_q <= '0;
      ctl7_q <= '0;
      ctl8_q <= '0;
      res_q  <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
      ctl6_q <= ctl5_q;
      ctl7_q <= ctl6_q;
      ctl8_q <= ctl7_q;
      res_q.valid    <= ctl8_q.valid;
      res_q.affected <= reach_ok8_q &&
                        (!ctl8_q.spot ||
                         (epos8_q && (esq8_q >= rhs1_8_q) && (!excl8_q || rad_ok8_q)));
    end
  end

  always_ff @(posedge clk_i) begin
    // Stage 1: apex offset along the axis, distance checks, exclusion partials.
    for (int k = 0; k < 3; k++) begin
      p1_q[k]   <= off_s * dir_s[k];
      d0_1_q[k] <= d0_i[k];
    end
    reach_ok1_q <= DSQ0_W'(reach2_i) >= dsq0_i;
    rad_ok1_q   <= DSQ0_W'(rad2_i) >= dsq0_i;
    e2pos1_q    <= !e2_i[E2_W-1] && (e2_i != '0);
    e2hh1_q     <= e2_hi * e2_hi;
    e2hl1_q     <= e2_hi * e2_lo;
    e2ll1_q     <= e2_lo * e2_lo;
    s0lo1_q     <= dsq0_i[K0-1:0] * s2_i;
    s0hi1_q     <= dsq0_i[DSQ0_W-1:K0] * s2_i;

    // Stage 2: round the offset vector, finish the exclusion squares.
    for (int k = 0; k < 3; k++) begin
      r2_q[k]   <= prr[k][P_W-1:Q1_FRAC];
      d0_2_q[k] <= d0_1_q[k];
    end
    reach_ok2_q <= reach_ok1_q;
    rad_ok2_q   <= rad_ok1_q;
    e2pos2_q    <= e2pos1_q;
    e2sq2_q     <= (CMP0_W'(e2hh1_q) << (2 * E2_H)) + (CMP0_W'(e2hl1_q) << (E2_H + 1)) +
                   CMP0_W'(e2ll1_q);
    rhs0_2_q    <= (CMP0_W'(s0hi1_q) << K0) + CMP0_W'(s0lo1_q);

    // Stage 3: vector from the pulled-back apex, backward-cone decision.
    for (int k = 0; k < 3; k++) begin
      d1_3_q[k] <= D1_W'(r2_q[k]) + D1_W'(d0_2_q[k]);
    end
    reach_ok3_q <= reach_ok2_q;
    rad_ok3_q   <= rad_ok2_q;
    excl3_q     <= e2pos2_q && (e2sq2_q >= rhs0_2_q);

    // Stage 4: split squares of the shifted vector and axis products.
    for (int k = 0; k < 3; k++) begin
      hh4_q[k] <= d1m[k][D1_W-1:D1_H] * d1m[k][D1_W-1:D1_H];
      hl4_q[k] <= d1m[k][D1_W-1:D1_H] * d1m[k][D1_H-1:0];
      ll4_q[k] <= d1m[k][D1_H-1:0] * d1m[k][D1_H-1:0];
      ep4_q[k] <= dir_s[k] * d1_3_q[k];
    end
    reach_ok4_q <= reach_ok3_q;
    rad_ok4_q   <= rad_ok3_q;
    excl4_q     <= excl3_q;

    // Stage 5: per-axis squares and the axis projection.
    for (int k = 0; k < 3; k++) begin
      d1sq5_q[k] <= (D1SQ_W'(hh4_q[k]) << (2 * D1_H)) + (D1SQ_W'(hl4_q[k]) << (D1_H + 1)) +
                    D1SQ_W'(ll4_q[k]);
    end
    e5_q        <= E_W'(ep4_q[0]) + E_W'(ep4_q[1]) + E_W'(ep4_q[2]);
    reach_ok5_q <= reach_ok4_q;
    rad_ok5_q   <= rad_ok4_q;
    excl5_q     <= excl4_q;

    // Stage 6: squared length, split square of the projection.
    dsq1_6_q    <= DSQ1_W'(d1sq5_q[0]) + DSQ1_W'(d1sq5_q[1]) + DSQ1_W'(d1sq5_q[2]);
    epos6_q     <= !e5_q[E_W-1] && (e5_q != '0);
    ehh6_q      <= e_hi * e_hi;
    ehl6_q      <= e_hi * e_lo;
    ell6_q      <= e_lo * e_lo;
    reach_ok6_q <= reach_ok5_q;
    rad_ok6_q   <= rad_ok5_q;
    excl6_q     <= excl5_q;

    // Stage 7: projection squared, squared length times cosine squared in chunks.
    esq7_q      <= (CMP1_W'(ehh6_q) << (2 * E_H)) + (CMP1_W'(ehl6_q) << (E_H + 1)) +
                   CMP1_W'(ell6_q);
    t0_7_q      <= dsq1_6_q[K1-1:0] * c2_i;
    t1_7_q      <= dsq1_6_q[2*K1-1:K1] * c2_i;
    t2_7_q      <= dsq1_6_q[DSQ1_W-1:2*K1] * c2_i;
    reach_ok7_q <= reach_ok6_q;
    rad_ok7_q   <= rad_ok6_q;
    excl7_q     <= excl6_q;
    epos7_q     <= epos6_q;

    // Stage 8: assemble the cone threshold.
    esq8_q      <= esq7_q;
    rhs1_8_q    <= CMP1_W'(t0_7_q) + (CMP1_W'(t1_7_q) << K1) + (CMP1_W'(t2_7_q) << (2 * K1));
    reach_ok8_q <= reach_ok7_q;
    rad_ok8_q   <= rad_ok7_q;
    excl8_q     <= excl7_q;
    epos8_q     <= epos7_q;
  end

  assign res_o = res_q;

  a_cone_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.valid |-> ##CONE_LAT res_o.valid)
    else $error("cone stage lost an item");

  a_cone_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> $past(ctl_i.valid, CONE_LAT))
    else $error("cone stage produced a result without an item");

  a_far_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl8_q.valid && !reach_ok8_q) |=> !res_o.affected)
    else $error("sphere out of reach was reported as affected");

  a_behind_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl8_q.valid && ctl8_q.spot && !epos8_q) |=> !res_o.affected)
    else $error("sphere behind the widened cone was reported as affected");

endmodule

// ----- rtl/core/light_sphere_cone_cull_test_core.sv -----
// Top level of the light versus bounding sphere cull core with its register port.
//
// Each item is one bounding sphere (center and radius, 1/16 world unit) that is
// tested against the light held in the configuration registers; every item
// produces exactly one result, affected_o, marked by done_o for one cycle. The
// core is a twelve-stage pipeline: a new item is taken on every clock (busy is
// always low), and results leave in the order of acceptance. The longest
// stages are the split 64-bit class multiplies of the squared lengths against
// the cosine and sine squares and the squared projections, which are spread
// over pairs of stages. The receiver cannot hold results off, so done_o must
// be sampled on every cycle. Registers sit at byte addresses 8*i on a 64-bit
// APB port and should only be written while no item is in flight; the cosine
// and sine squares are registered from the cone word and follow a write to it
// in the next cycle.
module light_sphere_cone_cull_test_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,

  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [lscc_pkg::COORD_BITS-1:0] sphere_x_i,
  input  logic signed [lscc_pkg::COORD_BITS-1:0] sphere_y_i,
  input  logic signed [lscc_pkg::COORD_BITS-1:0] sphere_z_i,
  input  logic [lscc_pkg::RAD_W-1:0]             sphere_radius_i,

  output logic                                   done_o,
  output logic                                   affected_o,

  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [lscc_pkg::PADDR_W-1:0]           paddr,
  input  logic [lscc_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [lscc_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import lscc_pkg::*;

  // Light configuration.
  logic signed [COORD_BITS-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [DIR_BITS-1:0]          dir_q;
  logic [RAD_W-1:0]             att_q;
  logic [CFG_DATA_W-1:0]        cone_q;
  logic                         kind_q;
  logic [TRIG2_W-1:0]           c2_q, s2_q;
  logic [TRIG_W-1:0]            cos_m, sin_m;

  logic      wr_en;
  lscc_reg_e reg_idx;

  // Pipeline front.
  logic                   accept;
  logic                   v1_q, v2_q, v3_q;
  logic signed [D0_W-1:0] d0_1_q [3];
  logic signed [D0_W-1:0] d0_2_q [3];
  logic signed [D0_W-1:0] d0_3_q [3];
  logic signed [D0_W-1:0] d0_d [3];
  logic [D0_W-1:0]        d0m [3];
  logic [RAD_W-1:0]       rad1_q;
  logic [REACH_W-1:0]     reach1_q;
  logic signed [DIR_W-1:0] dir_s [3];

  logic [SQ0_W-1:0]         sq0_2_q [3];
  logic signed [E2P_W-1:0]  q2_q [3];
  logic [2*REACH_W-1:0]     reach2_2_q, reach2_3_q;
  logic [2*RAD_W-1:0]       rad2_2_q, rad2_3_q;
  logic [OFFP_W-1:0]        offp2_q, offr;

  logic [DSQ0_W-1:0]        dsq0_3_q;
  logic signed [E2_W-1:0]   e2_3_q;
  logic [OFF_W-1:0]         off3_q;

  lscc_ctl_t cone_ctl;
  lscc_res_t cone_res;

  // The pipeline never stalls, so the register port is always ready and the
  // command side is never busy.
  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = lscc_reg_e'(paddr[PADDR_W-1:REG_IDX_LSB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
      dir_q   <= '0;
      att_q   <= '0;
      cone_q  <= '0;
      kind_q  <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_POS_X: pos_x_q <= pwdata[COORD_BITS-1:0];
        REG_POS_Y: pos_y_q <= pwdata[COORD_BITS-1:0];
        REG_POS_Z: pos_z_q <= pwdata[COORD_BITS-1:0];
        REG_DIR:   dir_q   <= pwdata[DIR_BITS-1:0];
        REG_ATT:   att_q   <= pwdata[RAD_W-1:0];
        REG_CONE:  cone_q  <= pwdata;
        REG_KIND:  kind_q  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_POS_X: prdata[COORD_BITS-1:0] = pos_x_q;
      REG_POS_Y: prdata[COORD_BITS-1:0] = pos_y_q;
      REG_POS_Z: prdata[COORD_BITS-1:0] = pos_z_q;
      REG_DIR:   prdata[DIR_BITS-1:0]   = dir_q;
      REG_ATT:   prdata[RAD_W-1:0]      = att_q;
      REG_CONE:  prdata                 = cone_q;
      REG_KIND:  prdata[0]              = kind_q;
      default:   prdata                 = '0;
    endcase
  end

  // Only the squares of the cosine and sine matter, so their signs drop out here.
  assign cos_m = cone_q[TRIG_W-1] ? TRIG_W'(-cone_q[TRIG_W-1:0]) : cone_q[TRIG_W-1:0];
  assign sin_m = cone_q[2*TRIG_W-1] ? TRIG_W'(-cone_q[2*TRIG_W-1:TRIG_W])
                                    : cone_q[2*TRIG_W-1:TRIG_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_q <= '0;
      s2_q <= '0;
    end else begin
      c2_q <= cos_m * cos_m;
      s2_q <= sin_m * sin_m;
    end
  end

  always_comb begin
    d0_d[0] = D0_W'(sphere_x_i) - D0_W'(pos_x_q);
    d0_d[1] = D0_W'(sphere_y_i) - D0_W'(pos_y_q);
    d0_d[2] = D0_W'(sphere_z_i) - D0_W'(pos_z_q);
    for (int k = 0; k < 3; k++) begin
      dir_s[k] = dir_q[DIR_W*k +: DIR_W];
      d0m[k]   = d0_1_q[k][D0_W-1] ? D0_W'(-d0_1_q[k]) : D0_W'(d0_1_q[k]);
    end
  end

  assign offr = offp2_q + OFFP_W'(OFF_RND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // Stage 1: offset from the light and the combined reach.
    for (int k = 0; k < 3; k++) begin
      d0_1_q[k] <= d0_d[k];
    end
    rad1_q   <= sphere_radius_i;
    reach1_q <= REACH_W'(att_q) + REACH_W'(sphere_radius_i);

    // Stage 2: squares, apex pull-back product and the backward projection terms.
    for (int k = 0; k < 3; k++) begin
      sq0_2_q[k] <= d0m[k] * d0m[k];
      q2_q[k]    <= dir_s[k] * d0_1_q[k];
      d0_2_q[k]  <= d0_1_q[k];
    end
    reach2_2_q <= reach1_q * reach1_q;
    rad2_2_q   <= rad1_q * rad1_q;
    offp2_q    <= rad1_q * cone_q[CFG_DATA_W-1:2*TRIG_W];

    // Stage 3: squared distance, negated projection, rounded apex offset.
    for (int k = 0; k < 3; k++) begin
      d0_3_q[k] <= d0_2_q[k];
    end
    dsq0_3_q   <= DSQ0_W'(sq0_2_q[0]) + DSQ0_W'(sq0_2_q[1]) + DSQ0_W'(sq0_2_q[2]);
    e2_3_q     <= -(E2_W'(q2_q[0]) + E2_W'(q2_q[1]) + E2_W'(q2_q[2]));
    off3_q     <= offr[OFFP_W-1:OFF_FRAC];
    reach2_3_q <= reach2_2_q;
    rad2_3_q   <= rad2_2_q;
  end

  assign cone_ctl = '{valid: v3_q, spot: kind_q};

  lscc_cone u_cone (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (cone_ctl),
    .d0_i     (d0_3_q),
    .dsq0_i   (dsq0_3_q),
    .reach2_i (reach2_3_q),
    .rad2_i   (rad2_3_q),
    .e2_i     (e2_3_q),
    .off_i    (off3_q),
    .dir_i    (dir_q),
    .c2_i     (c2_q),
    .s2_i     (s2_q),
    .res_o    (cone_res)
  );

  assign done_o     = cone_res.valid;
  assign affected_o = cone_res.affected;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PIPE_LAT done_o)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, PIPE_LAT))
    else $error("result strobe without an accepted item");

  a_front_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> $past(accept, 3))
    else $error("front stages invented an item");

endmodule

// ----- tb/sv/lscc_cull_checker.sv -----
// Checker for the light cull core: mirrors the registers, predicts each result and compares.
module lscc_cull_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic                                   busy_i,
  input  logic signed [lscc_pkg::COORD_BITS-1:0] sphere_x_i,
  input  logic signed [lscc_pkg::COORD_BITS-1:0] sphere_y_i,
  input  logic signed [lscc_pkg::COORD_BITS-1:0] sphere_z_i,
  input  logic [lscc_pkg::RAD_W-1:0]             sphere_radius_i,
  input  logic                                   done_i,
  input  logic                                   affected_i,
  input  logic                                   psel_i,
  input  logic                                   penable_i,
  input  logic                                   pwrite_i,
  input  logic [lscc_pkg::PADDR_W-1:0]           paddr_i,
  input  logic [lscc_pkg::CFG_DATA_W-1:0]        pwdata_i,
  input  logic                                   pready_i,
  output int                                     fail_count_o,
  output int                                     pending_o
);
  import lscc_pkg::*;

  typedef logic signed [127:0] acc_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [RAD_W-1:0]             r;
    logic                         affected;
  } cull_due_t;

  logic signed [COORD_BITS-1:0] pos_x, pos_y, pos_z;
  logic [47:0]                  dir_q;
  logic [RAD_W-1:0]             att_q;
  logic [63:0]                  cone_q;
  logic                         spot_q;

  cull_due_t affected_due[$];

  // Exact integer version of the cull decision; 128 bits hold every product without loss.
  function automatic logic light_reaches(input logic signed [COORD_BITS-1:0] cx, cy, cz,
                                         input logic [RAD_W-1:0] rad);
    acc_t ctr[3], pos[3], d0[3], d1[3], dirc[3];
    acc_t rad_w, att_w, reach, dsq0, dsq1, apex_off, invs, cos_w, sin_w, fwd, back;
    logic hit;
    ctr[0] = acc_t'(cx);
    ctr[1] = acc_t'(cy);
    ctr[2] = acc_t'(cz);
    pos[0] = acc_t'(pos_x);
    pos[1] = acc_t'(pos_y);
    pos[2] = acc_t'(pos_z);
    rad_w  = acc_t'(rad);
    att_w  = acc_t'(att_q);
    invs   = acc_t'(cone_q[63:32]);
    cos_w  = acc_t'($signed(cone_q[15:0]));
    sin_w  = acc_t'($signed(cone_q[31:16]));
    dsq0   = 0;
    for (int k = 0; k < 3; k++) begin
      d0[k]   = ctr[k] - pos[k];
      dirc[k] = acc_t'($signed(dir_q[16*k +: 16]));
      dsq0    = dsq0 + d0[k] * d0[k];
    end
    reach = att_w + rad_w;
    hit   = (reach * reach >= dsq0);
    if (hit && spot_q) begin
      // Pull the apex back by radius over sine, then test against the widened cone.
      apex_off = (rad_w * invs + 524288) >>> 20;
      fwd  = 0;
      back = 0;
      dsq1 = 0;
      for (int k = 0; k < 3; k++) begin
        d1[k] = d0[k] + ((apex_off * dirc[k] + 16384) >>> 15);
        fwd   = fwd + dirc[k] * d1[k];
        back  = back - dirc[k] * d0[k];
        dsq1  = dsq1 + d1[k] * d1[k];
      end
      if (fwd > 0 && fwd * fwd >= dsq1 * (cos_w * cos_w)) begin
        // Centers inside the backward cone behind the true apex must touch the apex.
        if (back > 0 && back * back >= dsq0 * (sin_w * sin_w))
          hit = (rad_w * rad_w >= dsq0);
        else
          hit = 1'b1;
      end else begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  task automatic note_failure(input string what);
    if (fail_count_o < 10) $display("%0t: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cull_due_t due;
    if (!rst_ni) begin
      pos_x  = '0;
      pos_y  = '0;
      pos_z  = '0;
      dir_q  = '0;
      att_q  = '0;
      cone_q = '0;
      spot_q = 1'b0;
      affected_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:REG_IDX_LSB])
          REG_POS_X: pos_x  = pwdata_i[COORD_BITS-1:0];
          REG_POS_Y: pos_y  = pwdata_i[COORD_BITS-1:0];
          REG_POS_Z: pos_z  = pwdata_i[COORD_BITS-1:0];
          REG_DIR:   dir_q  = pwdata_i[47:0];
          REG_ATT:   att_q  = pwdata_i[RAD_W-1:0];
          REG_CONE:  cone_q = pwdata_i[63:0];
          REG_KIND:  spot_q = pwdata_i[0];
          default: ;
        endcase
      end
      if (done_i) begin
        if (affected_due.size() == 0) begin
          note_failure($sformatf("result affected=%0b with no item in flight", affected_i));
        end else begin
          due = affected_due.pop_front();
          if (affected_i !== due.affected)
            note_failure($sformatf("sphere (%0d, %0d, %0d) radius %0d: expected %0b, got %0b",
                                   due.x, due.y, due.z, due.r, due.affected, affected_i));
        end
      end
      if (start_i && !busy_i) begin
        due.x = sphere_x_i;
        due.y = sphere_y_i;
        due.z = sphere_z_i;
        due.r = sphere_radius_i;
        due.affected = light_reaches(sphere_x_i, sphere_y_i, sphere_z_i, sphere_radius_i);
        affected_due.push_back(due);
      end
      pending_o = affected_due.size();
    end
  end

endmodule

// ----- tb/sv/tb_light_sphere_cone_cull_test_core.sv -----
// Testbench top for the light cull core: register setup, sphere stimulus and the verdict.
module tb_light_sphere_cone_cull_test_core;
  import lscc_pkg::*;

  // Cycles allowed after the last result before the verdict; the pipeline is twelve deep.
  localparam int  END_WAIT         = 16;
  localparam int  PHASES           = 10;
  localparam int  RANDOM_ITEMS     = 140;
  localparam int  UNMAPPED_REG_IDX = 7;
  localparam real PI               = 3.14159265358979;

  localparam logic signed [COORD_BITS-1:0] COORD_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [RAD_W-1:0]             RADIUS_MAX = '1;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic signed [COORD_BITS-1:0] sphere_x_i, sphere_y_i, sphere_z_i;
  logic [RAD_W-1:0]             sphere_radius_i;
  logic                         done_o;
  logic                         affected_o;
  logic                         psel, penable, pwrite;
  logic [PADDR_W-1:0]           paddr;
  logic [CFG_DATA_W-1:0]        pwdata;
  logic [CFG_DATA_W-1:0]        prdata;
  logic                         pready;

  int fail_count;
  int pending_count;

  // The stimulus keeps its own notion of the light so that it can aim spheres at it.
  int  light_px, light_py, light_pz, light_att;
  real dir_x, dir_y, dir_z;

  // Percentage of cycles in which no item is offered, and a count of items that go
  // out back to back regardless of it.
  int idle_pct;
  int quiet_items;

  light_sphere_cone_cull_test_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .sphere_x_i      (sphere_x_i),
    .sphere_y_i      (sphere_y_i),
    .sphere_z_i      (sphere_z_i),
    .sphere_radius_i (sphere_radius_i),
    .done_o          (done_o),
    .affected_o      (affected_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // The checker sees the same pins as the core and reports its failure count back here.
  lscc_cull_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .sphere_x_i      (sphere_x_i),
    .sphere_y_i      (sphere_y_i),
    .sphere_z_i      (sphere_z_i),
    .sphere_radius_i (sphere_radius_i),
    .done_i          (done_o),
    .affected_i      (affected_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // A hung core or a lost result ends the run here.
  initial begin
    #4000000;
    $display("light_sphere_cone_cull_test_core verification failed");
    $finish;
  end

  function automatic real frand(input real lo, input real hi);
    return lo + (hi - lo) * ($urandom_range(0, 1048576) / 1048576.0);
  endfunction

  function automatic logic [15:0] to_q15(input real v);
    longint q;
    q = longint'(v * 32768.0);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic logic [47:0] random_dir();
    real vx, vy, vz, len;
    do begin
      vx  = frand(-1.0, 1.0);
      vy  = frand(-1.0, 1.0);
      vz  = frand(-1.0, 1.0);
      len = $sqrt(vx * vx + vy * vy + vz * vz);
    end while (len < 0.1);
    return {to_q15(vz / len), to_q15(vy / len), to_q15(vx / len)};
  endfunction

  // Cone word as software builds it: cosine and sine in Q1.15, inverse sine in Q12.20.
  function automatic logic [63:0] cone_for_angle(input real deg);
    real    a;
    longint inv;
    a   = deg * PI / 180.0;
    inv = longint'(1048576.0 / $sin(a));
    if (inv > 64'sd4294967295) inv = 64'sd4294967295;
    return {inv[31:0], to_q15($sin(a)), to_q15($cos(a))};
  endfunction

  function automatic int pick_att();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(16, 4096);
      1:       return $urandom_range(4096, 1 << 16);
      2:       return $urandom_range(1 << 16, 1 << 22);
      default: return $urandom_range(0, (1 << RAD_W) - 1);
    endcase
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] to_coord(input real v);
    real                          lim;
    logic signed [COORD_BITS-1:0] c;
    lim = 2.0 ** (COORD_BITS - 1);
    if (v >= lim - 1.0) return COORD_MAX;
    if (v <= -lim) return COORD_MIN;
    c = COORD_BITS'(longint'(v));
    return c;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] edge_coord();
    case ($urandom_range(0, 3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // Most spheres are placed around the light along its direction, at distances that
  // straddle the attenuation radius and the cone edge; the rest are raw bits or extremes.
  task automatic pick_sphere(output logic signed [COORD_BITS-1:0] x, y, z,
                             output logic [RAD_W-1:0] r);
    real scale, t, spread;
    int  mode;
    mode = $urandom_range(0, 19);
    if (mode < 3) begin
      x = COORD_BITS'($urandom);
      y = COORD_BITS'($urandom);
      z = COORD_BITS'($urandom);
      r = RAD_W'($urandom);
    end else if (mode < 5) begin
      x = edge_coord();
      y = edge_coord();
      z = edge_coord();
      case ($urandom_range(0, 2))
        0:       r = '0;
        1:       r = RADIUS_MAX;
        default: r = RAD_W'($urandom);
      endcase
    end else begin
      scale  = (light_att < 64) ? 64.0 : light_att * 1.0;
      t      = frand(-0.4, 1.3) * scale;
      spread = frand(0.0, 0.9) * scale;
      x = to_coord(light_px + dir_x * t + frand(-1.0, 1.0) * spread);
      y = to_coord(light_py + dir_y * t + frand(-1.0, 1.0) * spread);
      z = to_coord(light_pz + dir_z * t + frand(-1.0, 1.0) * spread);
      if ($urandom_range(0, 7) == 0)
        r = '0;
      else
        r = RAD_W'(longint'(frand(0.0, 0.25) * scale));
    end
  endtask

  // Offers one item from a falling edge and returns once a rising edge has taken it.
  task automatic send_sphere(input logic signed [COORD_BITS-1:0] x, y, z,
                             input logic [RAD_W-1:0] r);
    @(negedge clk_i);
    if (quiet_items > 0)
      quiet_items--;
    else if ($urandom_range(0, 49) == 0)
      quiet_items = $urandom_range(10, 40);
    while (quiet_items == 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start           <= 1'b1;
    sphere_x_i      <= x;
    sphere_y_i      <= y;
    sphere_z_i      <= z;
    sphere_radius_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stops offering items and waits until every result in flight has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // Setup phase, then access phase; the write lands on the edge where pready is seen high.
  task automatic apb_write(input int idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx << REG_IDX_LSB);
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  // Writes the whole light. The cone word goes first so that its derived squares have
  // settled long before the first item of the phase.
  task automatic program_light(input int px, py, pz, input logic [47:0] dir, input int att,
                               input logic [63:0] cone, input logic kind);
    logic signed [COORD_BITS-1:0] c;
    int                           comp;
    apb_write(int'(REG_CONE), cone);
    apb_write(int'(REG_DIR), {16'h0000, dir});
    apb_write(int'(REG_POS_X), CFG_DATA_W'(px));
    apb_write(int'(REG_POS_Y), CFG_DATA_W'(py));
    apb_write(int'(REG_POS_Z), CFG_DATA_W'(pz));
    apb_write(int'(REG_ATT), CFG_DATA_W'(att));
    apb_write(int'(REG_KIND), CFG_DATA_W'(kind));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    c = COORD_BITS'(px);
    light_px = int'(c);
    c = COORD_BITS'(py);
    light_py = int'(c);
    c = COORD_BITS'(pz);
    light_pz = int'(c);
    light_att = att & ((1 << RAD_W) - 1);
    comp  = int'($signed(dir[15:0]));
    dir_x = comp / 32768.0;
    comp  = int'($signed(dir[31:16]));
    dir_y = comp / 32768.0;
    comp  = int'($signed(dir[47:32]));
    dir_z = comp / 32768.0;
  endtask

  initial begin
    logic signed [COORD_BITS-1:0] xs, ys, zs;
    logic [RAD_W-1:0]             rs;
    start           = 1'b0;
    sphere_x_i      = '0;
    sphere_y_i      = '0;
    sphere_z_i      = '0;
    sphere_radius_i = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    rst_ni          = 1'b0;
    light_px        = 0;
    light_py        = 0;
    light_pz        = 0;
    light_att       = 0;
    dir_x           = 0.0;
    dir_y           = 0.0;
    dir_z           = 0.0;
    quiet_items     = 0;
    idle_pct        = 0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      // Registers change only once the pipeline is empty.
      wait_drained();
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 53;
        default: idle_pct = 38;
      endcase

      case (ph)
        // Phase 0 runs on the reset values: a point light with zero reach at the origin.
        0: ;
        // A spot pointing along +z with a 45 degree outer cone.
        1: program_light(100, -200, 300, {16'h7fff, 32'h0}, 10000, cone_for_angle(45.0), 1'b1);
        // Point light at the corners of the coordinate range with the widest reach. A write
        // past the last register comes first and must change nothing.
        2: begin
          apb_write(UNMAPPED_REG_IDX, '1);
          program_light(int'(COORD_MIN), int'(COORD_MAX), int'(COORD_MIN), random_dir(),
                        int'(RADIUS_MAX), cone_for_angle(30.0), 1'b0);
        end
        // Direction of raw bits (not unit length) and a cone word of all ones, so the
        // cosine and sine codes are negative and the inverse sine is at its maximum.
        3: program_light(small_coord(), small_coord(), small_coord(),
                         48'({$urandom, $urandom}), pick_att(), '1, 1'b1);
        // Zero inverse sine: the apex stays at the light.
        4: program_light(small_coord(), small_coord(), small_coord(), random_dir(), pick_att(),
                         cone_for_angle(30.0) & 64'h0000_0000_ffff_ffff, 1'b1);
        // The widest and the narrowest cones software allows.
        5: program_light(small_coord(), small_coord(), small_coord(), random_dir(), pick_att(),
                         cone_for_angle(89.0), 1'b1);
        6: program_light(0, 0, 0, random_dir(), int'(RADIUS_MAX), cone_for_angle(0.001), 1'b1);
        // Everything zero but the spot flag.
        7: program_light(0, 0, 0, 48'h0, 0, 64'h0, 1'b1);
        8: program_light($urandom, $urandom, $urandom, random_dir(), pick_att(),
                         cone_for_angle(frand(1.0, 80.0)), 1'($urandom_range(0, 1)));
        // Direction along -x with the most negative Q1.15 code.
        default: program_light(small_coord(), small_coord(), small_coord(),
                               {16'h0000, 16'h0000, 16'h8000}, $urandom_range(0, 1 << 16),
                               cone_for_angle(frand(5.0, 60.0)), 1'b1);
      endcase

      if (ph == 0) begin
        // Zero reach: only spheres that touch the light position pass.
        send_sphere(0, 0, 0, 0);
        send_sphere(1, 0, 0, 0);
        send_sphere(1, 0, 0, 1);
        send_sphere(0, -3, 4, 5);
        send_sphere(0, -3, 4, 4);
        send_sphere(COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX);
        send_sphere(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
        send_sphere(COORD_MIN, COORD_MAX, 0, 0);
      end else if (ph == 1) begin
        // On the axis, off to the side, just behind the apex inside and outside the
        // sphere radius, at the rim of the reach, on the cone edge and at the apex itself.
        send_sphere(100, -200, 800, 10);
        send_sphere(600, -200, 400, 10);
        send_sphere(100, -200, 295, 10);
        send_sphere(100, -200, 250, 10);
        send_sphere(100, -200, 295, 0);
        send_sphere(100, -200, 10299, 0);
        send_sphere(100, -200, 10301, 0);
        send_sphere(3100, -200, 3300, 0);
        send_sphere(100, -200, 300, 0);
        send_sphere(COORD_MIN, COORD_MAX, COORD_MAX, RADIUS_MAX);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        pick_sphere(xs, ys, zs, rs);
        send_sphere(xs, ys, zs, rs);
      end
    end

    wait_drained();
    // A few more cycles catch any result the core emits beyond those expected.
    repeat (END_WAIT) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0)
      $display("light_sphere_cone_cull_test_core verification clean");
    else
      $display("light_sphere_cone_cull_test_core verification failed");
    $finish;
  end

endmodule
